// ----- design/quaternion_slerp_unit_macros.svh -----
// assertion helpers, clocked on clk and disabled during rst
`ifndef QUATERNION_SLERP_UNIT_MACROS_SVH
`define QUATERNION_SLERP_UNIT_MACROS_SVH

// property that must hold at every edge
`define QSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define QSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/qsl_pkg.sv -----
package qsl_pkg;

  localparam int FRAC_BITS        = 14;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int ITER             = (ANGLE_ITERATIONS > 32) ? 32 : ANGLE_ITERATIONS;
  // dot product is 2*FRAC_BITS fraction bits, rescaled to 30
  localparam int DOT_SHIFT        = 30 - 2 * FRAC_BITS;

  // cordic datapath widths
  localparam int CW    = 34;
  localparam int ANG_W = 33;

  // shared square root
  localparam int SQ_W    = 62;
  localparam int ROOT_W  = 31;
  localparam int ISQ_LAT = SQ_W / 2;

  localparam int CORDIC_LAT = ITER;

  // divider geometries
  localparam int LDIV_QW  = 16;
  localparam int LDIV_NW  = 23 + FRAC_BITS;
  localparam int LDIV_DW  = 24;
  localparam int LDIV_LAT = LDIV_QW + 1;
  localparam int SDIV_QW  = 32;
  localparam int SDIV_NW  = 64;
  localparam int SDIV_DW  = 33;
  localparam int SDIV_LAT = SDIV_QW + 1;

  localparam logic [14:0]        THR_RESET = 15'd32752;
  localparam logic [15:0]        BLEND_ONE = 16'd32768;
  localparam logic [30:0]        DOT_ONE   = 31'h4000_0000;
  localparam logic signed [32:0] W_LIMIT   = 33'sh0_8000_0000;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;
    logic [15:0]      t;
    logic             lin;
  } qsl_ctx_t;

  function automatic logic [30:0] atan_q30(input int unsigned idx);
    logic [30:0] v;
    unique case (idx)
      0:  v = 31'd843314857;
      1:  v = 31'd497837829;
      2:  v = 31'd263043837;
      3:  v = 31'd133525159;
      4:  v = 31'd67021687;
      5:  v = 31'd33543516;
      6:  v = 31'd16775851;
      7:  v = 31'd8388437;
      8:  v = 31'd4194283;
      9:  v = 31'd2097149;
      10: v = 31'd1048576;
      11: v = 31'd524288;
      12: v = 31'd262144;
      13: v = 31'd131072;
      14: v = 31'd65536;
      15: v = 31'd32768;
      16: v = 31'd16384;
      17: v = 31'd8192;
      18: v = 31'd4096;
      19: v = 31'd2048;
      20: v = 31'd1024;
      21: v = 31'd512;
      22: v = 31'd256;
      23: v = 31'd128;
      24: v = 31'd64;
      25: v = 31'd32;
      26: v = 31'd16;
      27: v = 31'd8;
      28: v = 31'd4;
      29: v = 31'd2;
      30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/qsl_delay.sv -----
module qsl_delay import qsl_pkg::*; #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) pipe[i] <= '0;
    end else if (en) begin
      pipe[0] <= d;
      for (int i = 1; i < DEPTH; i++) pipe[i] <= pipe[i-1];
    end
  end

  assign q = pipe[DEPTH-1];

endmodule

// ----- design/qsl_isqrt.sv -----
module qsl_isqrt import qsl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_n,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root
);

  logic [SQ_W-1:0] nr [ISQ_LAT];
  logic [SQ_W-1:0] rr [ISQ_LAT];
  logic            vr [ISQ_LAT];

  for (genvar s = 0; s < ISQ_LAT; s++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ISQ_LAT - 1 - s));
    logic [SQ_W-1:0] n_i, r_i, sum;
    logic            v_i;
    if (s == 0) begin : g_first
      assign n_i = in_n;
      assign r_i = '0;
      assign v_i = in_valid;
    end else begin : g_rest
      assign n_i = nr[s-1];
      assign r_i = rr[s-1];
      assign v_i = vr[s-1];
    end
    assign sum = r_i + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[s] <= 1'b0;
      end else if (en) begin
        vr[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_i >= sum) begin
          nr[s] <= n_i - sum;
          rr[s] <= (r_i >> 1) + BIT;
        end else begin
          nr[s] <= n_i;
          rr[s] <= r_i >> 1;
        end
      end
    end
  end

  assign out_valid = vr[ISQ_LAT-1];
  assign out_root  = rr[ISQ_LAT-1][ROOT_W-1:0];

endmodule

// ----- design/qsl_cordic.sv -----
module qsl_cordic import qsl_pkg::*; #(
  parameter bit VECTORING = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [CW-1:0]    in_x,
  input  logic signed [CW-1:0]    in_y,
  input  logic signed [ANG_W-1:0] in_z,
  output logic                    out_valid,
  output logic signed [CW-1:0]    out_x,
  output logic signed [CW-1:0]    out_y,
  output logic signed [ANG_W-1:0] out_z
);

  logic signed [CW-1:0]    xr [ITER];
  logic signed [CW-1:0]    yr [ITER];
  logic signed [ANG_W-1:0] zr [ITER];
  logic                    vr [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] AT = $signed(ANG_W'(atan_q30(i)));
    logic signed [CW-1:0]    x_i, y_i, dx, dy;
    logic signed [ANG_W-1:0] z_i;
    logic                    v_i, pos;
    if (i == 0) begin : g_first
      assign x_i = in_x;
      assign y_i = in_y;
      assign z_i = in_z;
      assign v_i = in_valid;
    end else begin : g_rest
      assign x_i = xr[i-1];
      assign y_i = yr[i-1];
      assign z_i = zr[i-1];
      assign v_i = vr[i-1];
    end
    assign dx  = y_i >>> i;
    assign dy  = x_i >>> i;
    // vectoring drives y toward zero, rotation drives z toward zero
    assign pos = VECTORING ? !(y_i > 0) : (z_i >= 0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[i] <= 1'b0;
      end else if (en) begin
        vr[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr[i] <= pos ? x_i - dx : x_i + dx;
        yr[i] <= pos ? y_i + dy : y_i - dy;
        zr[i] <= pos ? z_i - AT : z_i + AT;
      end
    end
  end

  assign out_valid = vr[ITER-1];
  assign out_x     = xr[ITER-1];
  assign out_y     = yr[ITER-1];
  assign out_z     = zr[ITER-1];

endmodule

// ----- design/qsl_div.sv -----
module qsl_div import qsl_pkg::*; #(
  parameter int NW = 37,
  parameter int DW = 24,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic          in_neg,
  input  logic [NW-1:0] in_mag,
  input  logic [DW-1:0] in_den,
  output logic          out_valid,
  output logic          out_neg,
  output logic          out_ovf,
  output logic [QW-1:0] out_q
);

  localparam int RW = ((NW + 1 > DW + QW) ? NW + 1 : DW + QW) + 1;

  logic          vr   [QW+1];
  logic          ngr  [QW+1];
  logic          ovr  [QW+1];
  logic [RW-1:0] remr [QW+1];
  logic [DW-1:0] denr [QW+1];
  logic [QW-1:0] qr   [QW+1];

  // rounding half away from zero: bias the magnitude by half the divisor
  logic [RW-1:0] rem0;
  assign rem0 = RW'(in_mag) + RW'(in_den >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (en) begin
      vr[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ngr[0]  <= in_neg;
      ovr[0]  <= (in_den != '0) && (rem0 >= (RW'(in_den) << QW));
      remr[0] <= rem0;
      denr[0] <= in_den;
      qr[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(denr[k]) << B;
    assign take = (denr[k] != '0) && (remr[k] >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k+1] <= 1'b0;
      end else if (en) begin
        vr[k+1] <= vr[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ngr[k+1]  <= ngr[k];
        ovr[k+1]  <= ovr[k];
        denr[k+1] <= denr[k];
        remr[k+1] <= take ? remr[k] - dsh : remr[k];
        qr[k+1]   <= qr[k] | (QW'(take) << B);
      end
    end
  end

  assign out_valid = vr[QW];
  assign out_neg   = ngr[QW];
  assign out_ovf   = ovr[QW];
  assign out_q     = qr[QW];

endmodule

// ----- design/quaternion_slerp_unit.sv -----
// quaternion slerp, fully pipelined
// s_tdata carries a pair of Q2.14 quaternions and the Q1.15 blend factor;
// a word is taken whenever s_tvalid and s_tready are both high. m_tdata
// carries the interpolated quaternion, m_tuser flags the normalized linear
// path. cfg_we/cfg_wdata load near_threshold, to be written while idle.
// Throughput is one word per cycle while the pipeline is not held. From
// acceptance to m_tvalid a word passes the dot product and setup, the
// shared square root (one result bit per stage), the vectoring cordic,
// angle scaling, the rotation cordics, the weight dividers (setup, then
// one quotient bit per stage), weighting, products and the output register.
// The linear path runs beside this chain and is delayed to meet it.
// Reset clears every valid bit and loads near_threshold with 32752.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated, and it resumes on the next
// cycle that m_tready rises.
module quaternion_slerp_unit import qsl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [14:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // r_w, r_x, r_y, r_z
  output logic [63:0]  m_tdata,
  // linear_path
  output logic         m_tuser
);

  `include "quaternion_slerp_unit_macros.svh"

  localparam int CTX_D = ISQ_LAT + 2 * CORDIC_LAT + 2 + SDIV_LAT;
  localparam int T_D   = ISQ_LAT + CORDIC_LAT;
  localparam int LIN_D = 2 * CORDIC_LAT + SDIV_LAT + 3 - LDIV_LAT;

  logic [14:0] near_threshold;
  logic        adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= THR_RESET;
    end else if (cfg_we) begin
      near_threshold <= cfg_wdata;
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: unpack and pairwise products
  logic signed [15:0] ain [4];
  logic signed [15:0] bin [4];
  logic signed [31:0] pin [4];
  logic [15:0]        blend_in;
  logic               v1;
  logic signed [15:0] a1 [4];
  logic signed [15:0] b1 [4];
  logic signed [31:0] p1 [4];
  logic [15:0]        t1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ain[i] = $signed(s_tdata[16*i +: 16]);
      bin[i] = $signed(s_tdata[64+16*i +: 16]);
      pin[i] = ain[i] * bin[i];
    end
    blend_in = s_tdata[143:128];
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        a1[i] <= ain[i];
        b1[i] <= bin[i];
        p1[i] <= pin[i];
      end
      t1 <= (blend_in > BLEND_ONE) ? BLEND_ONE : blend_in;
    end
  end

  // stage 2: dot product, shorter arc, path choice
  logic signed [33:0] dsum;
  logic [32:0]        dmag;
  logic [34:0]        x30f;
  logic               v2, lin2;
  logic signed [15:0] a2 [4];
  logic signed [16:0] b2 [4];
  logic [15:0]        t2;
  logic [30:0]        x30_2;

  assign dsum = 34'(p1[0]) + 34'(p1[1]) + 34'(p1[2]) + 34'(p1[3]);
  assign dmag = dsum[33] ? 33'(-dsum) : 33'(dsum);
  assign x30f = 35'(dmag) << DOT_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        a2[i] <= a1[i];
        b2[i] <= dsum[33] ? -17'(b1[i]) : 17'(b1[i]);
      end
      t2    <= t1;
      lin2  <= (x30f >> 15) > 35'(near_threshold);
      x30_2 <= (x30f > 35'(DOT_ONE)) ? DOT_ONE : x30f[30:0];
    end
  end

  // stage 3: linear blend and dot squared
  logic signed [17:0] bma  [4];
  logic signed [35:0] bprd [4];
  logic signed [35:0] lsum [4];
  logic signed [16:0] t2s;
  logic [61:0]        xsq;
  logic               v3, lin3;
  logic signed [15:0] a3 [4];
  logic signed [16:0] b3 [4];
  logic signed [35:0] l3 [4];
  logic [15:0]        t3;
  logic [30:0]        x30_3;
  logic [61:0]        xsq3;

  assign t2s = $signed({1'b0, t2});
  assign xsq = x30_2 * x30_2;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bma[i]  = 18'(b2[i]) - 18'(a2[i]);
      bprd[i] = bma[i] * t2s;
      lsum[i] = (36'(a2[i]) <<< 15) + bprd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        a3[i] <= a2[i];
        b3[i] <= b2[i];
        l3[i] <= lsum[i];
      end
      t3    <= t2;
      lin3  <= lin2;
      x30_3 <= x30_2;
      xsq3  <= xsq;
    end
  end

  // stage 4: scale down and square
  logic signed [23:0] mc  [4];
  logic signed [47:0] mcq [4];
  logic               v4, lin4;
  logic signed [15:0] a4 [4];
  logic signed [16:0] b4 [4];
  logic signed [23:0] m4 [4];
  logic [45:0]        msq4 [4];
  logic [15:0]        t4;
  logic [30:0]        x30_4;
  logic [61:0]        sq4;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mc[i]  = 24'(l3[i] >>> 8);
      mcq[i] = mc[i] * mc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        a4[i]   <= a3[i];
        b4[i]   <= b3[i];
        m4[i]   <= mc[i];
        msq4[i] <= mcq[i][45:0];
      end
      t4    <= t3;
      lin4  <= lin3;
      x30_4 <= x30_3;
      sq4   <= (62'(1) << 60) - xsq3;
    end
  end

  // stage 5: pick the square root operand for the path
  logic [46:0]        ss;
  logic               v5, lin5;
  logic signed [15:0] a5 [4];
  logic signed [16:0] b5 [4];
  logic signed [23:0] m5 [4];
  logic [15:0]        t5;
  logic [30:0]        x30_5;
  logic [61:0]        isq_in;

  assign ss = 47'(msq4[0]) + 47'(msq4[1]) + 47'(msq4[2]) + 47'(msq4[3]);

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        a5[i] <= a4[i];
        b5[i] <= b4[i];
        m5[i] <= m4[i];
      end
      t5     <= t4;
      lin5   <= lin4;
      x30_5  <= x30_4;
      isq_in <= lin4 ? 62'(ss) : sq4;
    end
  end

  // shared square root and the side data that waits for it
  logic              vq;
  logic [ROOT_W-1:0] root;
  logic [126:0]      side5, sideq;
  logic signed [23:0] mq [4];
  logic [30:0]       dotq;
  qsl_ctx_t          ctx5, ctxd;
  logic [15:0]       tq;

  qsl_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v5), .in_n(isq_in),
    .out_valid(vq), .out_root(root)
  );

  assign side5 = {m5[3], m5[2], m5[1], m5[0], x30_5};

  qsl_delay #(.W(127), .DEPTH(ISQ_LAT)) u_dly_side (
    .clk(clk), .rst(rst), .en(adv), .d(side5), .q(sideq)
  );

  always_comb begin
    dotq = sideq[30:0];
    for (int i = 0; i < 4; i++) mq[i] = $signed(sideq[31+24*i +: 24]);
    for (int i = 0; i < 4; i++) begin
      ctx5.a[i] = a5[i];
      ctx5.b[i] = b5[i];
    end
    ctx5.t   = t5;
    ctx5.lin = lin5;
  end

  qsl_delay #(.W($bits(qsl_ctx_t)), .DEPTH(CTX_D)) u_dly_ctx (
    .clk(clk), .rst(rst), .en(adv), .d(ctx5), .q(ctxd)
  );

  qsl_delay #(.W(16), .DEPTH(T_D)) u_dly_t (
    .clk(clk), .rst(rst), .en(adv), .d(t5), .q(tq)
  );

  // linear path: normalize by the root
  logic              lv  [4];
  logic              lng [4];
  logic              lov [4];
  logic [LDIV_QW-1:0] lq [4];
  logic              lvc;
  logic signed [15:0] lr [4];
  logic [64:0]       lin_pack, lin_dly;
  logic              ld_valid;

  for (genvar i = 0; i < 4; i++) begin : g_ldiv
    logic [22:0] mabs;
    assign mabs = mq[i][23] ? 23'(-mq[i]) : 23'(mq[i]);
    qsl_div #(.NW(LDIV_NW), .DW(LDIV_DW), .QW(LDIV_QW)) u_div (
      .clk(clk), .rst(rst), .en(adv), .in_valid(vq), .in_neg(mq[i][23]),
      .in_mag(LDIV_NW'(mabs) << FRAC_BITS), .in_den(root[LDIV_DW-1:0]),
      .out_valid(lv[i]), .out_neg(lng[i]), .out_ovf(lov[i]), .out_q(lq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) lvc <= 1'b0;
    else if (adv) lvc <= lv[0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        if (lov[i]) begin
          lr[i] <= lng[i] ? -16'sd32768 : 16'sd32767;
        end else if (lng[i]) begin
          lr[i] <= (lq[i] > 16'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, lq[i]}));
        end else begin
          lr[i] <= (lq[i] > 16'd32767) ? 16'sd32767 : $signed(lq[i]);
        end
      end
    end
  end

  assign lin_pack = {lvc, lr[3], lr[2], lr[1], lr[0]};

  qsl_delay #(.W(65), .DEPTH(LIN_D)) u_dly_lin (
    .clk(clk), .rst(rst), .en(adv), .d(lin_pack), .q(lin_dly)
  );

  assign ld_valid = lin_dly[64];

  // slerp path: theta0 from the vectoring cordic
  logic                    vv;
  logic signed [ANG_W-1:0] th0;

  qsl_cordic #(.VECTORING(1'b1)) u_acos (
    .clk(clk), .rst(rst), .en(adv), .in_valid(vq),
    .in_x($signed(CW'(dotq))), .in_y($signed(CW'(root))), .in_z('0),
    .out_valid(vv), .out_x(), .out_y(), .out_z(th0)
  );

  logic signed [16:0]      tqs;
  logic signed [49:0]      thp;
  logic                    vt, va;
  logic signed [ANG_W-1:0] th0t, tht;
  logic signed [ANG_W-1:0] ang [3];

  assign tqs = $signed({1'b0, tq});
  assign thp = th0 * tqs;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
      va <= 1'b0;
    end else if (adv) begin
      vt <= vv;
      va <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      th0t   <= th0;
      tht    <= ANG_W'(thp >>> 15);
      ang[0] <= th0t;
      ang[1] <= th0t - tht;
      ang[2] <= tht;
    end
  end

  // sines of theta0, theta0 - theta and theta
  logic                 sv;
  logic signed [CW-1:0] sn [3];

  for (genvar i = 0; i < 3; i++) begin : g_sin
    logic vo;
    qsl_cordic #(.VECTORING(1'b0)) u_sin (
      .clk(clk), .rst(rst), .en(adv), .in_valid(va),
      .in_x($signed(CW'(DOT_ONE))), .in_y('0), .in_z(ang[i]),
      .out_valid(vo), .out_x(), .out_y(sn[i]), .out_z()
    );
    if (i == 0) begin : g_v
      assign sv = vo;
    end
  end

  // weight ratios
  logic                 sn_pos, pos_d;
  logic [SDIV_DW-1:0]   sden;
  logic                 dv  [2];
  logic                 dng [2];
  logic                 dov [2];
  logic [SDIV_QW-1:0]   dq  [2];

  assign sn_pos = sn[0] > 0;
  assign sden   = sn_pos ? SDIV_DW'(sn[0]) : '0;

  for (genvar i = 0; i < 2; i++) begin : g_sdiv
    logic [CW-1:0] sabs;
    assign sabs = sn[i+1][CW-1] ? CW'(-sn[i+1]) : CW'(sn[i+1]);
    qsl_div #(.NW(SDIV_NW), .DW(SDIV_DW), .QW(SDIV_QW)) u_div (
      .clk(clk), .rst(rst), .en(adv), .in_valid(sv), .in_neg(sn[i+1][CW-1]),
      .in_mag(SDIV_NW'(sabs) << 30), .in_den(sden),
      .out_valid(dv[i]), .out_neg(dng[i]), .out_ovf(dov[i]), .out_q(dq[i])
    );
  end

  qsl_delay #(.W(1), .DEPTH(SDIV_LAT)) u_dly_pos (
    .clk(clk), .rst(rst), .en(adv), .d(sn_pos), .q(pos_d)
  );

  logic signed [32:0] wq [2];
  logic               vw, linw;
  logic signed [32:0] w0r, w1r;
  logic signed [15:0] aw [4];
  logic signed [16:0] bw [4];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (dov[i] || (dq[i] > 32'h8000_0000)) wq[i] = dng[i] ? -W_LIMIT : W_LIMIT;
      else wq[i] = dng[i] ? -$signed({1'b0, dq[i]}) : $signed({1'b0, dq[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vw <= 1'b0;
    else if (adv) vw <= dv[0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pos_d) begin
        w0r <= wq[0];
        w1r <= wq[1];
      end else begin
        // vanishing sine: weights fall back to 1 - t and t
        w0r <= $signed(33'(BLEND_ONE - ctxd.t) << 15);
        w1r <= $signed(33'(ctxd.t) << 15);
      end
      for (int i = 0; i < 4; i++) begin
        aw[i] <= $signed(ctxd.a[i]);
        bw[i] <= $signed(ctxd.b[i]);
      end
      linw <= ctxd.lin;
    end
  end

  // weighted products
  logic signed [48:0] pac [4];
  logic signed [49:0] pbc [4];
  logic               vm, linm;
  logic signed [48:0] pa [4];
  logic signed [49:0] pb [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pac[i] = w0r * aw[i];
      pbc[i] = w1r * bw[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (adv) vm <= vw;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        pa[i] <= pac[i];
        pb[i] <= pbc[i];
      end
      linm <= linw;
    end
  end

  // output register: round, saturate, merge paths
  logic signed [50:0] acc [4];
  logic signed [20:0] accs [4];
  logic signed [15:0] sr [4];
  logic [63:0]        rdata;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i]  = 51'(pa[i]) + 51'(pb[i]) + (51'sd1 <<< 29);
      accs[i] = 21'(acc[i] >>> 30);
      if (accs[i] > 21'sd32767) sr[i] = 16'sd32767;
      else if (accs[i] < -21'sd32768) sr[i] = -16'sd32768;
      else sr[i] = 16'(accs[i]);
      rdata[16*i +: 16] = linm ? lin_dly[16*i +: 16] : sr[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= vm;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= rdata;
      m_tuser <= linm;
    end
  end

  `QSL_ASSERT(a_path_align, (vm == ld_valid), "linear and slerp chains out of step")
  `QSL_ASSERT_NEXT(a_freeze, (!s_tready), ($stable(vq) && $stable(vm)), "pipeline moved in stall")
  `QSL_ASSERT(a_weight_range, (!vw || (w0r <= W_LIMIT && w0r >= -W_LIMIT)), "weight out of range")

endmodule

// ----- sim/tb.sv -----
module tb;
  import qsl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 106;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [15:0] w, x, y, z;
    logic        lin;
  } slerp_out_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [14:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         m_tuser;

  quaternion_slerp_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  logic [14:0]  threshold = THR_RESET;
  slerp_out_t   expected_q[$];
  int           errors = 0;
  int           words_sent = 0, words_checked = 0, linear_seen = 0;
  int           idle_cycles = 0;
  bit           hold_off = 1'b0;
  bit           no_gaps = 1'b0;

  // table of cordic angles, Q.30 radians
  function automatic longint atan_tab(int i);
    longint tab[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2, 1, 0};
    return tab[i & 31];
  endfunction

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned m, q;
    m = num < 0 ? longint'(-num) : num;
    q = (m + longint'(den) / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint rot_sine(longint ang);
    longint x, y, z, dx, dy;
    x = 64'sd1 << 30;
    y = 0;
    z = ang;
    for (int i = 0; i < ITER; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab(i);
      end else begin
        x += dx; y -= dy; z += atan_tab(i);
      end
    end
    return y;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < ITER; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_tab(i);
      end else begin
        x -= dx; y += dy; z -= atan_tab(i);
      end
    end
    return z;
  endfunction

  function automatic slerp_out_t slerp_predict(logic [143:0] word);
    longint a[4], b[4], r[4], m[4], d, t, dot, s30, th0, th, sn0, w0, w1, l;
    longint unsigned x30, ss, len;
    slerp_out_t res;
    bit lin;
    d = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(word[16*i +: 16]));
      b[i] = longint'($signed(word[16*(i+4) +: 16]));
      d += a[i] * b[i];
    end
    t = word[143:128];
    if (t > 32768) t = 32768;
    if (d < 0) begin
      for (int i = 0; i < 4; i++) b[i] = -b[i];
      d = -d;
    end
    x30 = longint'(d) << DOT_SHIFT;
    lin = (x30 >> 15) > threshold;
    if (x30 > (64'd1 << 30)) x30 = 64'd1 << 30;
    if (lin) begin
      ss = 0;
      for (int i = 0; i < 4; i++) begin
        l = a[i] * 32768 + (b[i] - a[i]) * t;
        m[i] = floor_shr(l, 8);
        ss += m[i] * m[i];
      end
      len = int_sqrt(ss);
      for (int i = 0; i < 4; i++)
        r[i] = len == 0 ? 0 :
          clip(round_div(m[i] * (64'sd1 << FRAC_BITS), len), -32768, 32767);
    end else begin
      dot = x30;
      s30 = int_sqrt((64'd1 << 60) - x30 * x30);
      th0 = vec_angle(s30, dot);
      th = floor_shr(th0 * t, 15);
      sn0 = rot_sine(th0);
      if (sn0 > 0) begin
        w0 = round_div(rot_sine(th0 - th) * (64'sd1 << 30), sn0);
        w1 = round_div(rot_sine(th) * (64'sd1 << 30), sn0);
      end else begin
        w0 = (32768 - t) << 15;
        w1 = t << 15;
      end
      w0 = clip(w0, -(64'sd1 << 31), 64'sd1 << 31);
      w1 = clip(w1, -(64'sd1 << 31), 64'sd1 << 31);
      for (int i = 0; i < 4; i++)
        r[i] = clip(floor_shr(w0 * a[i] + w1 * b[i] + (64'sd1 << 29), 30),
                    -32768, 32767);
    end
    res.w = r[0][15:0];
    res.x = r[1][15:0];
    res.y = r[2][15:0];
    res.z = r[3][15:0];
    res.lin = lin;
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // tvalid stays up between back-to-back words; a gap or a drain drops it
  task automatic send_word(logic [143:0] word);
    int g;
    g = no_gaps ? 0 : gap_len();
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tdata <= word;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(slerp_predict(word));
    words_sent++;
  endtask

  task automatic send_quat(logic [63:0] qa, logic [63:0] qb, logic [15:0] t);
    send_word({t, qb, qa});
  endtask

  task automatic drain_and_idle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] v);
    drain_and_idle();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold = v;
  endtask

  function automatic logic [63:0] quat(int w, int x, int y, int z);
    return {16'(z), 16'(y), 16'(x), 16'(w)};
  endfunction

  // random quaternion of arbitrary 16-bit components, or a perturbed copy for a near pair
  function automatic logic [63:0] rand_quat();
    return {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  function automatic logic [63:0] near_quat(logic [63:0] q, int spread, bit flip);
    logic [63:0] r;
    int c;
    for (int i = 0; i < 4; i++) begin
      c = int'($signed(q[16*i +: 16])) + $urandom_range(0, 2*spread) - spread;
      if (flip) c = -c;
      r[16*i +: 16] = 16'(clip(c, -32768, 32767));
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_blend();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'($urandom);
    if (p == 1) return BLEND_ONE;
    if (p == 2) return 16'd0;
    return 16'($urandom_range(0, 32768));
  endfunction

  task automatic test_directed();
    send_quat(quat(16384, 0, 0, 0), quat(16384, 0, 0, 0), 16'd16384);
    send_quat(quat(16384, 0, 0, 0), quat(0, 16384, 0, 0), 16'd0);
    send_quat(quat(16384, 0, 0, 0), quat(0, 16384, 0, 0), BLEND_ONE);
    send_quat(quat(16384, 0, 0, 0), quat(0, 16384, 0, 0), 16'd16384);
    send_quat(quat(16384, 0, 0, 0), quat(0, 16384, 0, 0), 16'hFFFF);
    send_quat(quat(16384, 0, 0, 0), quat(-16384, 0, 0, 0), 16'd8192);
    send_quat(quat(16384, 0, 0, 0), quat(-11585, 11585, 0, 0), 16'd20000);
    // all-zero quaternions, taken on the slerp path
    send_quat(quat(0, 0, 0, 0), quat(0, 0, 0, 0), 16'd100);
    send_quat(quat(16384, 0, 0, 0), quat(-16384, 0, 0, 0), 16'd16384);
    // dot far above one
    send_quat(quat(32767, 32767, 32767, 32767), quat(32767, 32767, 32767, 32767), 16'd5);
    send_quat(quat(-32768, -32768, -32768, -32768), quat(32767, -32768, 32767, -32768), 16'd9);
    send_quat(quat(-32768, -32768, -32768, -32768), quat(-32768, -32768, -32768, -32768),
              BLEND_ONE);
    send_quat(quat(16384, 0, 0, 0), quat(16380, 300, 0, 0), 16'd12345);
    send_quat(quat(0, 0, 16384, 0), quat(0, 0, 0, 16384), 16'd32767);
    // tiny dot, theta0 near a right angle
    send_quat(quat(1, 0, 0, 0), quat(0, 1, 0, 0), 16'd16384);
    send_quat(quat(1, 0, 0, 0), quat(1, 0, 0, 0), 16'd16384);
    send_quat(quat(5000, -7000, 3000, 12000), quat(-4000, 9000, 1000, -2000), 16'd30000);
  endtask

  task automatic test_random(int n);
    logic [63:0] qa, qb;
    int p;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 9);
      qa = rand_quat();
      if (p < 3) qb = rand_quat();
      else if (p < 6) qb = near_quat(qa, 64, p == 5);
      else qb = near_quat(qa, $urandom_range(200, 8000), p[0]);
      send_quat(qa, qb, rand_blend());
    end
  endtask

  // sink stalls for a long stretch while words keep coming with no gaps
  task automatic test_backpressure();
    hold_off = 1'b1;
    no_gaps = 1'b1;
    test_random(250);
    no_gaps = 1'b0;
  endtask

  task automatic test_thresholds();
    write_threshold(15'd0);
    test_random(150);
    write_threshold(15'd32767);
    test_random(150);
    write_threshold(15'd16384);
    test_random(150);
    write_threshold(15'd30000);
    test_random(150);
    write_threshold(THR_RESET);
  endtask

  // sink: random stalls, plus the long hold-off
  initial begin
    int g;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        g = gap_len();
        if (g != 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    slerp_out_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        words_checked++;
        if (m_tuser) linear_seen++;
        if (m_tdata[15:0] !== exp_r.w) begin
          $error("r_w expected %0d got %0d", $signed(exp_r.w), $signed(m_tdata[15:0]));
          errors++;
        end
        if (m_tdata[31:16] !== exp_r.x) begin
          $error("r_x expected %0d got %0d", $signed(exp_r.x), $signed(m_tdata[31:16]));
          errors++;
        end
        if (m_tdata[47:32] !== exp_r.y) begin
          $error("r_y expected %0d got %0d", $signed(exp_r.y), $signed(m_tdata[47:32]));
          errors++;
        end
        if (m_tdata[63:48] !== exp_r.z) begin
          $error("r_z expected %0d got %0d", $signed(exp_r.z), $signed(m_tdata[63:48]));
          errors++;
        end
        if (m_tuser !== exp_r.lin) begin
          $error("linear_path expected %0d got %0d", exp_r.lin, m_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word or config write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(450);
    test_backpressure();
    test_thresholds();
    test_random(330);
    drain_and_idle();
    $display("sent %0d words, checked %0d results (%0d on the linear path)",
             words_sent, words_checked, linear_seen);
    $display("covered extremes, reset and four other thresholds, long output stall");
    if (errors == 0 && expected_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/qsl_pkg.sv
design/qsl_delay.sv
design/qsl_isqrt.sv
design/qsl_cordic.sv
design/qsl_div.sv
design/quaternion_slerp_unit.sv
sim/tb.sv
